// ===== sv/pcrb_pkg.sv =====
// pcrb_pkg: constants, types and helper functions for the measurement register bank
// shared by pcrb_regfile, pcrb_sha1 and pcr_bank_extend_read; no dependencies
`timescale 1ns / 1ps

package pcrb_pkg;

    // bank geometry
    localparam int NUM_REGS = 24;
    localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int REG_W    = 160;
    localparam int BLK_W    = 512;

    // operation codes
    localparam logic OP_READ   = 1'b0;
    localparam logic OP_EXTEND = 1'b1;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // response header for a good result
    localparam logic [7:0] RESP_TAG  = 8'hC4;
    localparam logic [7:0] RESP_SIZE = 8'h1E;

    // sha-1 initial hash value and round count
    localparam logic [31:0] SHA_H0 = 32'h67452301;
    localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
    localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
    localparam logic [31:0] SHA_H3 = 32'h10325476;
    localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;
    localparam int          SHA_ROUNDS = 80;
    localparam int          RND_W = 7;

    // padding for the fixed 40-byte message: marker byte and 320-bit length
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [15:0] MSG_BITS = 16'h0140;

    // memory port request from the control logic
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [REG_W-1:0] wr_data;
    } pcrb_mem_req_t;

    // hash unit status
    typedef struct packed {
        logic busy;
        logic done;
    } pcrb_sha_stat_t;

    // round constant for a round number
    function automatic logic [31:0] sha_k(input logic [RND_W-1:0] rnd);
        logic [31:0] k;
        if (rnd < RND_W'(20))
            k = 32'h5A827999;
        else if (rnd < RND_W'(40))
            k = 32'h6ED9EBA1;
        else if (rnd < RND_W'(60))
            k = 32'h8F1BBCDC;
        else
            k = 32'hCA62C1D6;
        return k;
    endfunction

    // round function for a round number
    function automatic logic [31:0] sha_f(input logic [RND_W-1:0] rnd,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
        logic [31:0] f;
        if (rnd < RND_W'(20))
            f = (b & c) | (~b & d);
        else if (rnd < RND_W'(40))
            f = b ^ c ^ d;
        else if (rnd < RND_W'(60))
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

// ===== sv/pcr_bank_extend_read.sv =====
// pcr_bank_extend_read: bank of measurement registers with read and sha-1 extend
// top level; uses pcrb_pkg, pcrb_regfile and pcrb_sha1
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid / in_stall) carries one request item: operation,
//   reg_index and, for an extend, 20 data bytes in ext_data_hi/mid/lo.
//   Output channel (out_valid / out_stall) carries one result item per request:
//   status, the 160-bit register value after the operation, response_tag and
//   response_size (zeros with status 1 for an index out of range).
//   Requests are processed one at a time. For an out-of-range index the result
//   goes straight to the done state; a read passes through one memory read
//   first; an extend goes through the register read, the hash start, the 80
//   rounds of the sha-1 round unit, the final addition and the write back into
//   the bank. The next item is taken only once the result has gone to the
//   output register, so a new request is not accepted before the last is through.
//   A finished result sits in an output register, so the next request is taken
//   while the previous result still waits; a request completes into the output
//   register only once it is free, so out_stall holds the block in that state.
//   Reset clears every register of the bank to zero at once (no clearing
//   pass) and empties the output register.
//

module pcr_bank_extend_read (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  reg_index,
    input  logic [31:0] ext_data_hi,
    input  logic [63:0] ext_data_mid,
    input  logic [63:0] ext_data_lo,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [31:0] digest_hi,
    output logic [63:0] digest_mid,
    output logic [63:0] digest_lo,
    output logic [7:0]  response_tag,
    output logic [7:0]  response_size
);
    import pcrb_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_HASH = 5'b00100,
        ST_DONE = 5'b01000,
        ST_WAIT = 5'b10000
    } pcrb_state_t;

    pcrb_state_t      state_reg, state_next;
    pcrb_mem_req_t    mem_req;
    pcrb_sha_stat_t   sha_stat;
    logic [REG_W-1:0] rd_data;
    logic [REG_W-1:0] sha_digest;
    logic [BLK_W-1:0] sha_block;
    logic             sha_start;
    logic             in_take;
    logic             idx_bad;
    logic             out_free;

    logic             op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [REG_W-1:0] ext_reg;
    logic             res_status_reg;
    logic [REG_W-1:0] res_digest_reg;

    logic             out_valid_reg;
    logic             out_status_reg;
    logic [REG_W-1:0] out_digest_reg;

    assign in_take  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign idx_bad  = (reg_index >= 8'(NUM_REGS));
    assign out_free = !out_valid_reg || !out_stall;

    // padded one-block message: old value, extend bytes, marker, length
    assign sha_block = {rd_data, ext_reg, PAD_MARK,
                        {(BLK_W - 2*REG_W - 8 - 16){1'b0}}, MSG_BITS};
    assign sha_start = (state_reg == ST_RD) && (op_reg == OP_EXTEND);

    // memory requests: read on accept, write back when the hash completes
    always_comb
    begin
        mem_req.rd_en   = in_take && !idx_bad;
        mem_req.rd_addr = reg_index[IDX_W-1:0];
        mem_req.wr_en   = (state_reg == ST_HASH) && sha_stat.done;
        mem_req.wr_addr = idx_reg;
        mem_req.wr_data = sha_digest;
    end

    pcrb_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    pcrb_sha1 u_sha1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sha_start),
        .block  (sha_block),
        .stat   (sha_stat),
        .digest (sha_digest)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = idx_bad ? ST_DONE : ST_RD;
            end
            ST_RD:
            begin
                state_next = (op_reg == OP_EXTEND) ? ST_HASH : ST_DONE;
            end
            ST_HASH:
            begin
                if (sha_stat.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = out_free ? ST_IDLE : ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // request capture and result register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= operation;
            idx_reg <= reg_index[IDX_W-1:0];
            ext_reg <= {ext_data_hi, ext_data_mid, ext_data_lo};
            if (idx_bad)
            begin
                res_status_reg <= STATUS_BAD;
                res_digest_reg <= '0;
            end
            else
            begin
                res_status_reg <= STATUS_OK;
            end
        end
        if (state_reg == ST_RD)
        begin
            res_digest_reg <= rd_data;
        end
        if ((state_reg == ST_HASH) && sha_stat.done)
        begin
            res_digest_reg <= sha_digest;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (((state_reg == ST_DONE) || (state_reg == ST_WAIT)) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (((state_reg == ST_DONE) || (state_reg == ST_WAIT)) && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_digest_reg <= res_digest_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign digest_hi     = out_digest_reg[159:128];
    assign digest_mid    = out_digest_reg[127:64];
    assign digest_lo     = out_digest_reg[63:0];
    assign response_tag  = (out_status_reg == STATUS_OK) ? RESP_TAG : 8'h00;
    assign response_size = (out_status_reg == STATUS_OK) ? RESP_SIZE : 8'h00;

    // bank is written only at the end of an extend
    a_wr_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (sha_stat.done && (op_reg == OP_EXTEND)))
        else $error("bank write outside extend completion");

    // hash completion only seen while waiting for it
    a_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        sha_stat.done |-> (state_reg == ST_HASH))
        else $error("hash completion outside hash state");

    // hash unit idle whenever a new request may be taken
    a_idle_sha_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !sha_stat.busy)
        else $error("hash unit busy while idle");

    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_digest_reg)))
        else $error("stalled result changed");

endmodule

// ===== sv/pcrb_regfile.sv =====
// pcrb_regfile: synchronous bank memory of NUM_REGS 160-bit entries, registered read
// per-entry valid bits give the all-zero reset value; depends on pcrb_pkg
`timescale 1ns / 1ps

module pcrb_regfile (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pcrb_pkg::pcrb_mem_req_t        req,
    output logic [pcrb_pkg::REG_W-1:0]     rd_data
);
    import pcrb_pkg::*;

    logic [REG_W-1:0]    mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [REG_W-1:0]    rd_data_reg;
    logic                rd_hit_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // written-entry flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // never-written entry reads as zero
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ===== sv/pcrb_sha1.sv =====
// pcrb_sha1: iterative sha-1 compression of one 512-bit block, one round per cycle
// starts from the standard initial value; depends on pcrb_pkg
`timescale 1ns / 1ps

module pcrb_sha1 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pcrb_pkg::BLK_W-1:0]     block,
    output pcrb_pkg::pcrb_sha_stat_t       stat,
    output logic [pcrb_pkg::REG_W-1:0]     digest
);
    import pcrb_pkg::*;

    logic [31:0]      w_reg [16];
    logic [31:0]      a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [RND_W-1:0] rnd_reg;
    logic             busy_reg;
    logic             fin_reg;
    logic             done_reg;
    logic [REG_W-1:0] digest_reg;
    logic [31:0]      t_next;
    logic [31:0]      w_new;
    logic [31:0]      w_mix;

    // round datapath
    always_comb
    begin
        t_next = {a_reg[26:0], a_reg[31:27]} + sha_f(rnd_reg, b_reg, c_reg, d_reg)
                 + e_reg + sha_k(rnd_reg) + w_reg[0];
        w_mix  = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new  = {w_mix[30:0], w_mix[31]};
    end

    // message schedule window and working variables
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int j = 0; j < 16; j++)
            begin
                w_reg[j] <= block[BLK_W-1-32*j -: 32];
            end
            a_reg <= SHA_H0;
            b_reg <= SHA_H1;
            c_reg <= SHA_H2;
            d_reg <= SHA_H3;
            e_reg <= SHA_H4;
        end
        else if (busy_reg)
        begin
            for (int j = 0; j < 15; j++)
            begin
                w_reg[j] <= w_reg[j+1];
            end
            w_reg[15] <= w_new;
            a_reg <= t_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (fin_reg)
        begin
            digest_reg <= {SHA_H0 + a_reg, SHA_H1 + b_reg, SHA_H2 + c_reg,
                           SHA_H3 + d_reg, SHA_H4 + e_reg};
        end
    end

    // round counter and completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (rnd_reg == RND_W'(SHA_ROUNDS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
                rnd_reg <= rnd_reg + RND_W'(1);
            end
        end
    end

    assign stat.busy = busy_reg | fin_reg;
    assign stat.done = done_reg;
    assign digest    = digest_reg;

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for pcr_bank_extend_read, read and sha-1 extend of the register bank
// depends on pcrb_pkg and the rtl under sv/; carries its own sha-1 predictor of the bank
`timescale 1ns / 1ps

module tb_top;

    import pcrb_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 1330;
    localparam int DRAIN_CYCLES  = 100;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DIRECTED_ROWS = 19;

    // data patterns for the directed rows
    localparam logic [159:0] ZEROS = '0;
    localparam logic [159:0] ONES  = '1;
    localparam logic [159:0] ALT_A = {20{8'hA5}};
    localparam logic [159:0] ALT_5 = {20{8'h5A}};
    localparam logic [159:0] INCR  = {32'h00010203, 64'h04050607_08090A0B,
                                      64'h0C0D0E0F_10111213};

    // how a row is checked: by the predictor or by a value typed in
    typedef enum logic [1:0] {CHK_MODEL, CHK_CLEAR, CHK_BAD} chk_t;

    typedef struct packed {
        logic         op;
        logic [7:0]   idx;
        logic [159:0] data;
        chk_t         chk;
    } step_t;

    typedef struct packed {
        logic         status;
        logic [159:0] digest;
        logic [7:0]   tag;
        logic [7:0]   size;
    } resp_t;

    typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = OP_READ;
    logic [7:0]  reg_index = '0;
    logic [31:0] ext_data_hi = '0;
    logic [63:0] ext_data_mid = '0;
    logic [63:0] ext_data_lo = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic [31:0] digest_hi;
    logic [63:0] digest_mid;
    logic [63:0] digest_lo;
    logic [7:0]  response_tag;
    logic [7:0]  response_size;

    logic [159:0] pcr_shadow [NUM_REGS];
    resp_t        expected_responses [$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           burst_left = 0;
    stall_mode_t  stall_mode = STALL_NONE;
    int           stall_phase_left = 0;
    int           stall_run_left = 0;
    logic         stall_level = 1'b0;

    // directed rows: reset contents, bank edges, bad indexes, chained extends
    step_t plan [DIRECTED_ROWS] = '{
        '{OP_READ,   8'd0,   ZEROS, CHK_CLEAR},  // freshly reset register
        '{OP_READ,   8'd23,  ONES,  CHK_CLEAR},  // top register, data ignored on read
        '{OP_READ,   8'd24,  ZEROS, CHK_BAD},    // first index past the bank
        '{OP_EXTEND, 8'd24,  ONES,  CHK_BAD},
        '{OP_READ,   8'd255, ONES,  CHK_BAD},
        '{OP_EXTEND, 8'd255, ZEROS, CHK_BAD},
        '{OP_EXTEND, 8'd128, ALT_A, CHK_BAD},
        '{OP_EXTEND, 8'd0,   ZEROS, CHK_MODEL},  // zero data into a zero register
        '{OP_READ,   8'd0,   ONES,  CHK_MODEL},
        '{OP_EXTEND, 8'd0,   ONES,  CHK_MODEL},  // extend on top of an extend
        '{OP_EXTEND, 8'd23,  ONES,  CHK_MODEL},
        '{OP_READ,   8'd23,  ZEROS, CHK_MODEL},
        '{OP_READ,   8'd22,  ALT_A, CHK_CLEAR},  // neighbor left alone
        '{OP_EXTEND, 8'd1,   ALT_A, CHK_MODEL},
        '{OP_EXTEND, 8'd1,   ALT_5, CHK_MODEL},
        '{OP_READ,   8'd1,   ZEROS, CHK_MODEL},
        '{OP_EXTEND, 8'd31,  ALT_5, CHK_BAD},
        '{OP_READ,   8'd0,   ZEROS, CHK_MODEL},
        '{OP_EXTEND, 8'd12,  INCR,  CHK_MODEL}
    };

    pcr_bank_extend_read u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .reg_index     (reg_index),
        .ext_data_hi   (ext_data_hi),
        .ext_data_mid  (ext_data_mid),
        .ext_data_lo   (ext_data_lo),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .digest_hi     (digest_hi),
        .digest_mid    (digest_mid),
        .digest_lo     (digest_lo),
        .response_tag  (response_tag),
        .response_size (response_size)
    );

    always #CLK_HALF clk = ~clk;

    // sha-1 of old register value followed by 20 measured bytes, one padded block
    function automatic logic [159:0] sha1_chain(input logic [159:0] prev,
                                                input logic [159:0] meas);
        logic [511:0] blk;
        logic [31:0]  sched [80];
        logic [31:0]  a, b, c, d, e, mix, rconst, tmp;
        blk = {prev, meas, PAD_MARK, 168'd0, MSG_BITS};
        for (int i = 0; i < 16; i++)
            sched[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 80; i++)
        begin
            tmp = sched[i - 3] ^ sched[i - 8] ^ sched[i - 14] ^ sched[i - 16];
            sched[i] = {tmp[30:0], tmp[31]};
        end
        a = SHA_H0;
        b = SHA_H1;
        c = SHA_H2;
        d = SHA_H3;
        e = SHA_H4;
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                mix = (b & c) | (~b & d);
                rconst = 32'h5A827999;
            end
            else if (i < 40)
            begin
                mix = b ^ c ^ d;
                rconst = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                mix = (b & c) | (b & d) | (c & d);
                rconst = 32'h8F1BBCDC;
            end
            else
            begin
                mix = b ^ c ^ d;
                rconst = 32'hCA62C1D6;
            end
            tmp = {a[26:0], a[31:27]} + mix + e + rconst + sched[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        return {a + SHA_H0, b + SHA_H1, c + SHA_H2, d + SHA_H3, e + SHA_H4};
    endfunction

    // bank behavior: apply one request to the shadow bank, return its response
    function automatic resp_t bank_predict(input step_t s);
        resp_t r;
        if (s.idx >= NUM_REGS)
        begin
            r = {STATUS_BAD, 160'd0, 8'd0, 8'd0};
        end
        else
        begin
            if (s.op == OP_EXTEND)
                pcr_shadow[s.idx[IDX_W-1:0]] = sha1_chain(pcr_shadow[s.idx[IDX_W-1:0]],
                                                          s.data);
            r = {STATUS_OK, pcr_shadow[s.idx[IDX_W-1:0]], RESP_TAG, RESP_SIZE};
        end
        return r;
    endfunction

    // random request: mostly good indexes, a hot few for deep extend chains
    function automatic step_t random_request();
        step_t s;
        int    pick;
        pick = $urandom_range(0, 99);
        s.chk = CHK_MODEL;
        s.op = (pick < 55) ? OP_EXTEND : OP_READ;
        if (pick % 7 == 0)
            s.idx = 8'($urandom_range(NUM_REGS, 255));
        else if (pick % 3 == 0)
            s.idx = 8'($urandom_range(0, 3));
        else
            s.idx = 8'($urandom_range(0, NUM_REGS - 1));
        case ($urandom_range(0, 9))
            0: s.data = ZEROS;
            1: s.data = ONES;
            default: s.data = {$urandom, $urandom, $urandom, $urandom, $urandom};
        endcase
        return s;
    endfunction

    task automatic report_failure(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // send one item in bursts with random gaps; called and returns at a falling edge
    task automatic issue_request(input step_t s);
        int    gap;
        resp_t want;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 3);
                2: gap = $urandom_range(4, 20);
                default: gap = $urandom_range(21, 40);
            endcase
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid     <= 1'b1;
        operation    <= s.op;
        reg_index    <= s.idx;
        ext_data_hi  <= s.data[159:128];
        ext_data_mid <= s.data[127:64];
        ext_data_lo  <= s.data[63:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = bank_predict(s);
        case (s.chk)
            CHK_CLEAR: want = {STATUS_OK, 160'd0, RESP_TAG, RESP_SIZE};
            CHK_BAD:   want = {STATUS_BAD, 160'd0, 8'd0, 8'd0};
            default:   ;
        endcase
        expected_responses.push_back(want);
        burst_left--;
        @(negedge clk);
    endtask

    // receiver stall pattern: quiet, sparse or long runs, switching now and then
    always @(negedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            stall_phase_left = $urandom_range(50, 300);
        end
        stall_phase_left--;
        case (stall_mode)
            STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_RUNS:
            begin
                if (stall_run_left == 0)
                begin
                    stall_level = ~stall_level;
                    stall_run_left = stall_level ? $urandom_range(1, 30) : $urandom_range(1, 4);
                end
                stall_run_left--;
                out_stall <= stall_level;
            end
            default: out_stall <= 1'b0;
        endcase
    end

    // response checker against the oldest expectation
    always @(posedge clk)
    begin
        resp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_responses.size() == 0)
            begin
                report_failure("result with no request outstanding");
            end
            else
            begin
                want = expected_responses.pop_front();
                if (status !== want.status)
                    report_failure($sformatf("status got %0b expected %0b",
                                             status, want.status));
                if (digest_hi !== want.digest[159:128])
                    report_failure($sformatf("digest_hi got %h expected %h",
                                             digest_hi, want.digest[159:128]));
                if (digest_mid !== want.digest[127:64])
                    report_failure($sformatf("digest_mid got %h expected %h",
                                             digest_mid, want.digest[127:64]));
                if (digest_lo !== want.digest[63:0])
                    report_failure($sformatf("digest_lo got %h expected %h",
                                             digest_lo, want.digest[63:0]));
                if (response_tag !== want.tag)
                    report_failure($sformatf("response_tag got %h expected %h",
                                             response_tag, want.tag));
                if (response_size !== want.size)
                    report_failure($sformatf("response_size got %h expected %h",
                                             response_size, want.size));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // reset, directed table, random requests, drain
    initial
    begin
        foreach (pcr_shadow[i])
            pcr_shadow[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue_request(plan[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            issue_request(random_request());
        in_valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
